>>> rtl/bldf_pkg.sv
// ----------------------------------------------------------------------------
// bldf_pkg - shared types for the length message deframer
// Phase and status codes, per-item state and result records, and the
// packed-BCD length helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bldf_pkg;

    // framing bytes and limits
    localparam logic [7:0]  ESC_BYTE      = 8'h1B;
    localparam logic [7:0]  CR_BYTE       = 8'h0D;
    localparam logic [7:0]  LF_BYTE       = 8'h0A;
    localparam logic [7:0]  FORMAT_RESET  = 8'd6;
    localparam logic [13:0] MIN_LENGTH    = 14'd7;

    // frame byte positions with a meaning of their own
    localparam logic [13:0] POS_LEN_HIGH  = 14'd1;
    localparam logic [13:0] POS_LEN_LOW   = 14'd2;
    localparam logic [13:0] POS_FORMAT    = 14'd4;
    localparam logic [13:0] POS_BODY      = 14'd5;

    // port packing widths
    localparam int OFFSET_W   = 14;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 5;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_FRAME,
        PH_DISCARD
    } phase_t;

    typedef enum logic [2:0] {
        ST_CONT,
        ST_GOOD,
        ST_NOHDR,
        ST_FORMAT,
        ST_BADLEN,
        ST_TRUNC,
        ST_DISC
    } status_t;

    typedef struct packed {
        phase_t              phase;
        logic [13:0]         declared_length;
        logic [13:0]         byte_position;
        logic [7:0]          length_high_byte;
        logic [7:0]          previous_byte;
    } state_t;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                in_frame;
        logic                frame_first;
        logic                frame_last;
        logic [OFFSET_W-1:0] frame_offset;
        status_t             status;
    } result_t;

    // two BCD digits to binary (0..99); bit 7 flags a non-decimal digit
    function automatic logic [7:0] bcd_pair(input logic [7:0] b);
        logic [3:0] hi;
        logic [3:0] lo;
        logic [6:0] val;
        hi  = b[7:4];
        lo  = b[3:0];
        val = 7'({hi, 3'b000}) + 7'({hi, 1'b0}) + 7'(lo);
        return {(hi > 4'd9) || (lo > 4'd9), val};
    endfunction

endpackage

`default_nettype wire

>>> rtl/bldf_step.sv
// ----------------------------------------------------------------------------
// bldf_step - per-byte deframing logic
// Works out the tagged result and the next framing state for one item
// from the current state, the incoming byte and the wanted format.
// ----------------------------------------------------------------------------
`default_nettype none

module bldf_step (
    input  bldf_pkg::state_t  state,
    input  logic [7:0]        data_byte,
    input  logic              datagram_last,
    input  logic [7:0]        wanted_format,
    output bldf_pkg::state_t  state_next,
    output bldf_pkg::result_t result
);
    import bldf_pkg::*;

    logic [7:0]  high_pair;
    logic [7:0]  low_pair;
    logic [13:0] length_value;
    logic        length_bad;
    logic [13:0] pos_inc;

    // packed-BCD total length from the two length bytes
    always_comb begin
        high_pair    = bcd_pair(state.length_high_byte);
        low_pair     = bcd_pair(data_byte);
        length_bad   = high_pair[7] | low_pair[7];
        length_value = 14'(high_pair[6:0] * 7'd100) + 14'(low_pair[6:0]);
        pos_inc      = state.byte_position + 14'd1;
    end

    // framing decision for this byte
    always_comb begin
        logic closed;
        closed     = 1'b0;
        state_next = state;
        result     = '{out_byte: data_byte, in_frame: 1'b0, frame_first: 1'b0,
                       frame_last: 1'b0, frame_offset: '0, status: ST_CONT};
        case (state.phase)
            PH_FRAME: begin
                result.in_frame     = 1'b1;
                result.frame_offset = state.byte_position;
                if (state.byte_position == POS_LEN_HIGH) begin
                    state_next.length_high_byte = data_byte;
                end else if (state.byte_position == POS_LEN_LOW) begin
                    state_next.declared_length = length_bad ? 14'd0 : length_value;
                end else if (state.byte_position == POS_FORMAT) begin
                    if (data_byte != wanted_format) begin
                        result.status = ST_FORMAT;
                        closed        = 1'b1;
                    end else if (state.declared_length < MIN_LENGTH) begin
                        result.status = ST_BADLEN;
                        closed        = 1'b1;
                    end
                end else if (state.byte_position >= POS_BODY &&
                             pos_inc == state.declared_length) begin
                    closed        = 1'b1;
                    result.status = (state.previous_byte == CR_BYTE &&
                                     data_byte == LF_BYTE) ? ST_GOOD : ST_BADLEN;
                end
                state_next.previous_byte = data_byte;
                if (closed) begin
                    result.frame_last        = 1'b1;
                    state_next.phase         = (result.status == ST_GOOD || datagram_last)
                                               ? PH_HUNT : PH_DISCARD;
                    state_next.byte_position = '0;
                end else if (datagram_last) begin
                    result.frame_last        = 1'b1;
                    result.status            = ST_TRUNC;
                    state_next.phase         = PH_HUNT;
                    state_next.byte_position = '0;
                end else begin
                    state_next.byte_position = pos_inc;
                end
            end
            PH_DISCARD: begin
                result.status = ST_DISC;
                if (datagram_last) begin
                    state_next.phase = PH_HUNT;
                end
            end
            PH_HUNT: begin
                if (data_byte == ESC_BYTE) begin
                    result.in_frame             = 1'b1;
                    result.frame_first          = 1'b1;
                    state_next.previous_byte    = data_byte;
                    state_next.declared_length  = '0;
                    state_next.length_high_byte = '0;
                    if (datagram_last) begin
                        result.frame_last        = 1'b1;
                        result.status            = ST_TRUNC;
                        state_next.byte_position = '0;
                    end else begin
                        state_next.phase         = PH_FRAME;
                        state_next.byte_position = 14'd1;
                    end
                end else begin
                    result.status = ST_NOHDR;
                end
                if (datagram_last) begin
                    state_next.phase = PH_HUNT;
                end
            end
            default: begin
                state_next.phase = PH_HUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/bcd_length_message_deframer.sv
// ----------------------------------------------------------------------------
// bcd_length_message_deframer - escape-led frame deframer
// Hunts for escape-led frames with a packed-BCD length and CR LF trailer
// and tags every byte with frame position and status.
// ----------------------------------------------------------------------------
// the tagged item is registered and shows on the m_ side in the cycle after input accept
// throughput: one item per cycle while the m_ side is ready; the framing state and the output
//   register both update in the accepting cycle, so bytes stream back to back
// reset: synchronous active-low aresetn returns to hunting, clears the
//   framing state, empties the output register and sets the format to 6
`default_nettype none

module bcd_length_message_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_we,
    input  logic [7:0]                     cfg_wdata,   // wanted_format
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bldf_pkg::S_TDATA_W-1:0] s_tdata,     // [7:0] data_byte
    input  logic                           s_tlast,     // datagram_last
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bldf_pkg::M_TDATA_W-1:0] m_tdata,     // [7:0] out_byte,
                                                        // [21:8] frame_offset
    output logic [bldf_pkg::M_TUSER_W-1:0] m_tuser,     // [0] in_frame,
                                                        // [1] frame_first,
                                                        // [4:2] status
    output logic                           m_tlast      // frame_last
);
    import bldf_pkg::*;

    logic [7:0] format_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    result_next;
    result_t    result_reg;
    logic       m_tvalid_reg;
    logic       s_accept;

    // output register frees up when empty or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    bldf_step u_step (
        .state         (state_reg),
        .data_byte     (s_tdata[7:0]),
        .datagram_last (s_tlast),
        .wanted_format (format_reg),
        .state_next    (state_next),
        .result        (result_next)
    );

    // wanted format register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= FORMAT_RESET;
        end else if (cfg_we) begin
            format_reg <= cfg_wdata;
        end
    end

    // framing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_HUNT, declared_length: '0, byte_position: '0,
                           length_high_byte: '0, previous_byte: '0};
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, result_reg.frame_offset, result_reg.out_byte};
    assign m_tuser  = {result_reg.status, result_reg.frame_first, result_reg.in_frame};
    assign m_tlast  = result_reg.frame_last;

    // end of datagram always leaves the block hunting
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> state_reg.phase == PH_HUNT)
        else $error("not hunting after datagram end");

    // a byte taken while discarding comes out marked discarded
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && state_reg.phase == PH_DISCARD
        |=> m_tvalid && m_tuser[4:2] == ST_DISC && !m_tuser[0])
        else $error("discard byte not tagged");

    // every accepted item shows up in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid_reg)
        else $error("accepted item lost");

    // position counter only runs inside a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase != PH_FRAME |-> state_reg.byte_position == '0)
        else $error("position left over outside frame");

    // an accepted escape while hunting opens a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && state_reg.phase == PH_HUNT && s_tdata[7:0] == ESC_BYTE
        |=> m_tuser[1] && m_tuser[0] && m_tdata[21:8] == '0)
        else $error("escape did not open frame");

endmodule

`default_nettype wire

>>> tb/bcd_length_message_deframer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_length_message_deframer_checker - tagged byte scoreboard
// Watches the byte stream into the deframer and the tagged stream out of it,
// tracks the framing state on its own to work out each tag, and compares
// every tagged item with the oldest one still outstanding.
// ----------------------------------------------------------------------------

module bcd_length_message_deframer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [4:0]  m_tuser,
    input  logic        m_tlast,
    output int          tag_mismatches,
    output int          tags_outstanding,
    output int          tags_checked,
    output int          good_frames
);
    import bldf_pkg::*;

    // own copy of the framing state and the format register
    phase_t      ph;
    logic [13:0] decl_len;
    logic [13:0] byte_pos;
    logic [7:0]  len_hi;
    logic [7:0]  prev;
    logic [7:0]  fmt;

    result_t     tagged_bytes[$];
    int          n_bad     = 0;
    int          n_checked = 0;
    int          n_good    = 0;

    // works out the tag of one byte and advances the framing state
    function automatic result_t deframe_byte(input logic [7:0] b, input logic last);
        result_t r;
        int      pos;
        logic    closed;
        r.out_byte     = b;
        r.in_frame     = 1'b0;
        r.frame_first  = 1'b0;
        r.frame_last   = 1'b0;
        r.frame_offset = '0;
        r.status       = ST_CONT;
        closed         = 1'b0;
        pos            = int'(byte_pos);
        case (ph)
            PH_FRAME: begin
                r.in_frame     = 1'b1;
                r.frame_offset = byte_pos;
                if (byte_pos == POS_LEN_HIGH) begin
                    len_hi = b;
                end else if (byte_pos == POS_LEN_LOW) begin
                    // four packed digits, any non-decimal nibble gives zero
                    if (len_hi[7:4] > 4'd9 || len_hi[3:0] > 4'd9 ||
                        b[7:4] > 4'd9 || b[3:0] > 4'd9) begin
                        decl_len = '0;
                    end else begin
                        decl_len = 14'(int'(len_hi[7:4]) * 1000 + int'(len_hi[3:0]) * 100 +
                                       int'(b[7:4]) * 10 + int'(b[3:0]));
                    end
                end else if (byte_pos == POS_FORMAT) begin
                    if (b != fmt) begin
                        r.status = ST_FORMAT;
                        closed   = 1'b1;
                    end else if (decl_len < MIN_LENGTH) begin
                        r.status = ST_BADLEN;
                        closed   = 1'b1;
                    end
                end else if (pos >= int'(POS_BODY) && pos + 1 == int'(decl_len)) begin
                    closed   = 1'b1;
                    r.status = (prev == CR_BYTE && b == LF_BYTE) ? ST_GOOD : ST_BADLEN;
                end
                prev = b;
                if (closed) begin
                    r.frame_last = 1'b1;
                    ph           = (r.status == ST_GOOD || last) ? PH_HUNT : PH_DISCARD;
                    byte_pos     = '0;
                end else if (last) begin
                    r.frame_last = 1'b1;
                    r.status     = ST_TRUNC;
                    ph           = PH_HUNT;
                    byte_pos     = '0;
                end else begin
                    byte_pos = byte_pos + 14'd1;
                end
            end
            PH_DISCARD: begin
                r.status = ST_DISC;
                if (last) ph = PH_HUNT;
            end
            default: begin
                if (b == ESC_BYTE) begin
                    r.in_frame    = 1'b1;
                    r.frame_first = 1'b1;
                    prev          = b;
                    decl_len      = '0;
                    len_hi        = '0;
                    if (last) begin
                        r.frame_last = 1'b1;
                        r.status     = ST_TRUNC;
                        byte_pos     = '0;
                    end else begin
                        ph       = PH_FRAME;
                        byte_pos = POS_LEN_HIGH;
                    end
                end else begin
                    r.status = ST_NOHDR;
                end
                if (last) ph = PH_HUNT;
            end
        endcase
        return r;
    endfunction

    // tagged items leave before new bytes enter, both sampled at the edge
    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        if (!aresetn) begin
            ph       = PH_HUNT;
            decl_len = '0;
            byte_pos = '0;
            len_hi   = '0;
            prev     = '0;
            fmt      = FORMAT_RESET;
            tagged_bytes.delete();
        end else begin
            if (cfg_we) fmt = cfg_wdata;

            if (m_tvalid && m_tready) begin
                got.out_byte     = m_tdata[7:0];
                got.frame_offset = m_tdata[21:8];
                got.in_frame     = m_tuser[0];
                got.frame_first  = m_tuser[1];
                got.status       = status_t'(m_tuser[4:2]);
                got.frame_last   = m_tlast;
                if (tagged_bytes.size() == 0) begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10)
                        $display("unexpected item: byte %02h in_frame %0b first %0b last %0b",
                                 got.out_byte, got.in_frame, got.frame_first, got.frame_last);
                end else begin
                    want = tagged_bytes.pop_front();
                    if (got !== want || m_tdata[23:22] !== 2'b00) begin
                        n_bad = n_bad + 1;
                        if (n_bad <= 10) begin
                            $display("mismatch on item %0d: expected byte %02h in_frame %0b",
                                     n_checked, want.out_byte, want.in_frame);
                            $display("  first %0b last %0b offset %0d status %0d",
                                     want.frame_first, want.frame_last, want.frame_offset,
                                     want.status);
                            $display("  got byte %02h in_frame %0b first %0b last %0b",
                                     m_tdata[7:0], m_tuser[0], m_tuser[1], m_tlast);
                            $display("  offset %0d status %0d pad %0h",
                                     m_tdata[21:8], m_tuser[4:2], m_tdata[23:22]);
                        end
                    end
                    if (want.status == ST_GOOD) n_good = n_good + 1;
                end
                n_checked = n_checked + 1;
            end

            if (s_tvalid && s_tready)
                tagged_bytes.push_back(deframe_byte(s_tdata, s_tlast));
        end
        tag_mismatches   <= n_bad;
        tags_outstanding <= tagged_bytes.size();
        tags_checked     <= n_checked;
        good_frames      <= n_good;
    end

endmodule

>>> tb/bcd_length_message_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_length_message_deframer_tb - deframer testbench
// Feeds directed datagrams and then random ones built mostly of well-formed
// escape-led frames with random content and injected faults, under three
// format settings and three idling patterns, and lets the checker compare
// every tagged byte.
// ----------------------------------------------------------------------------

module bcd_length_message_deframer_tb;
    import bldf_pkg::*;

    localparam int UUT_LATENCY = 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int SEG_BYTES   = 350;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    int          tag_mismatches;
    int          tags_outstanding;
    int          tags_checked;
    int          good_frames;

    int          send_idle_pct = 6;
    int          recv_idle_pct = 83;
    logic        hold_active   = 1'b0;
    logic [7:0]  cur_format;
    logic [7:0]  dgram[$];
    int          bytes_sent    = 0;
    int          dgrams_sent   = 0;
    int          cycle_count   = 0;

    bcd_length_message_deframer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    bcd_length_message_deframer_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .tag_mismatches   (tag_mismatches),
        .tags_outstanding (tags_outstanding),
        .tags_checked     (tags_checked),
        .good_frames      (good_frames)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stalls at random, or holds off entirely while hold_active
    always @(posedge aclk) begin
        if (hold_active) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // one byte, with a random gap before it, held until accepted
    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_datagram();
        foreach (dgram[i]) send_item(dgram[i], i == dgram.size() - 1);
        dgrams_sent = dgrams_sent + 1;
    endtask

    // sender pauses until every tagged byte is back
    task automatic wait_for_tags();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tags_outstanding != 0);
        repeat (UUT_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_format(input logic [7:0] v);
        cfg_we     <= 1'b1;
        cfg_wdata  <= v;
        cur_format  = v;
        @(posedge aclk);
        cfg_we     <= 1'b0;
    endtask

    // noise byte, rarely an escape
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == ESC_BYTE && $urandom_range(0, 3) != 0) b = ~b;
        return b;
    endfunction

    // datagram of one to three frames with noise, faults and truncation
    task automatic make_datagram();
        int         len;
        int         kind;
        int         cut;
        logic [3:0] dig[4];
        logic [7:0] fmt_byte;
        dgram.delete();
        repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 2)) dgram.push_back(noise_byte());
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0) len = $urandom_range(60, 200);
            else len = $urandom_range(7, 24);
            if (kind < 7) len = $urandom_range(0, 6);
            dig[0] = 4'(len / 1000);
            dig[1] = 4'((len / 100) % 10);
            dig[2] = 4'((len / 10) % 10);
            dig[3] = 4'(len % 10);
            // non-decimal length digit
            if (kind >= 7 && kind < 13) dig[$urandom_range(0, 3)] = 4'($urandom_range(10, 15));
            fmt_byte = cur_format;
            if (kind >= 13 && kind < 20) fmt_byte = cur_format ^ 8'($urandom_range(1, 255));
            dgram.push_back(ESC_BYTE);
            dgram.push_back({dig[0], dig[1]});
            dgram.push_back({dig[2], dig[3]});
            dgram.push_back(8'($urandom));
            dgram.push_back(fmt_byte);
            for (int k = 5; k < len - 2; k++) dgram.push_back(8'($urandom));
            if (len >= 7) begin
                dgram.push_back(CR_BYTE);
                dgram.push_back(LF_BYTE);
                // broken trailer
                if (kind >= 20 && kind < 28)
                    dgram[dgram.size() - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            end
        end
        repeat ($urandom_range(0, 2)) dgram.push_back(noise_byte());
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, dgram.size());
            while (dgram.size() > cut) void'(dgram.pop_back());
        end
    endtask

    task automatic run_random(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            make_datagram();
            send_datagram();
        end
    endtask

    initial begin
        cur_format = FORMAT_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: skipped byte, good frame with escape inside, bad trailer
        // on the closing and last byte
        dgram = '{8'hFF,
                  ESC_BYTE, 8'h00, 8'h07, ESC_BYTE, FORMAT_RESET, CR_BYTE, LF_BYTE,
                  ESC_BYTE, 8'h00, 8'h07, 8'h00, FORMAT_RESET, LF_BYTE, CR_BYTE};
        send_datagram();
        // wrong format with maximum length, rest discarded
        dgram = '{ESC_BYTE, 8'h99, 8'h99, 8'h00, 8'h05, 8'h00};
        send_datagram();
        // non-decimal length digit
        dgram = '{ESC_BYTE, 8'hFA, 8'h00, 8'h00, FORMAT_RESET};
        send_datagram();
        // truncated inside a frame, then an escape that is the last byte
        dgram = '{ESC_BYTE, 8'h00};
        send_datagram();
        dgram = '{ESC_BYTE};
        send_datagram();
        wait_for_tags();

        // sender mostly busy, receiver mostly stalled
        write_format(8'h00);
        run_random(SEG_BYTES);
        wait_for_tags();

        // the other way round
        send_idle_pct  = 83;
        recv_idle_pct <= 6;
        write_format(8'hFF);
        run_random(SEG_BYTES);
        wait_for_tags();

        // no idling, with one long receiver hold-off so the input backs up
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        write_format(8'($urandom_range(0, 255)));
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active <= 1'b0;
            end
        join_none
        run_random(SEG_BYTES);
        wait_for_tags();

        $display("sent %0d bytes in %0d datagrams, %0d tagged items checked, %0d good frames",
                 bytes_sent, dgrams_sent, tags_checked, good_frames);
        $display("formats 06, 00, ff and %02h, stalls on either side and a long hold-off",
                 cur_format);
        if (tag_mismatches == 0 && tags_outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
